// ===== rtl/core/etof_pkg.sv =====
`default_nettype none
package etof_pkg;

  localparam int X_W     = 12;
  localparam int DL_W    = 11;
  localparam int TO_W    = 14;
  localparam int FC_W    = 19;
  localparam int FT_W    = 17;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 19;
  localparam int CIDX_W  = 2;

  localparam int D2_W    = 22;
  localparam int D3_W    = 33;
  localparam int COEF_W  = 52;
  localparam int SUM_W   = 64;
  localparam int MAG_W   = 62;
  localparam int EK_W    = 60;
  localparam int KN_W    = 39;
  localparam int NUM_W   = 40;
  localparam int S_W     = 31;
  localparam int T_W     = 42;

  localparam int FC_SCALE = 1000000;

  localparam logic [CIDX_W-1:0] CFG_DEAD_LAYER      = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TIME_OFFSET     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FLIGHT_CONSTANT = 2'd2;

  localparam logic [DL_W-1:0]        DL_RESET = 11'd500;
  localparam logic signed [TO_W-1:0] TO_RESET = 14'sd0;
  localparam logic [FC_W-1:0]        FC_RESET = 19'd145943;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_NEG  = 2'd2,
    ST_SAT  = 2'd3
  } st_t;

  typedef struct packed {
    logic [X_W-1:0]           x;
    logic signed [TO_W-1:0]   to;
    logic [KN_W-1:0]          num;
    logic signed [COEF_W-1:0] n2;
    logic signed [COEF_W-1:0] n1;
    logic signed [COEF_W-1:0] n0;
    logic                     neg;
    st_t                      cls;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/etof_div.sv =====
`default_nettype none
module etof_div #(
  parameter int DW = 8,
  parameter int VW = 4,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld  [1:DW];
  logic [DW-1:0] num  [1:DW];
  logic [VW-1:0] rem  [1:DW];
  logic [VW-1:0] den  [1:DW];
  logic [SW-1:0] side [1:DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] n_in;
    logic [VW-1:0] r_in;
    logic [VW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = in_num;
      assign r_in = '0;
      assign d_in = in_den;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k];
      assign n_in = num[k];
      assign r_in = rem[k];
      assign d_in = den[k];
      assign s_in = side[k];
    end

    assign trial = {r_in, n_in[DW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      num[k+1]  <= {n_in[DW-2:0], take};
      rem[k+1]  <= take ? diff[VW-1:0] : trial[VW-1:0];
      den[k+1]  <= d_in;
      side[k+1] <= s_in;
    end
  end

  assign out_valid = vld[DW];
  assign out_quo   = num[DW];
  assign out_side  = side[DW];

endmodule

module etof_cdiv #(
  parameter int DW  = 62,
  parameter int DEN = 1000,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  // radix 2^16 long division, one digit per two stages
  localparam int DG  = 16;
  localparam int ND  = 4;
  localparam int PW  = DG * ND;
  localparam int RW  = $clog2(DEN);
  localparam int CW  = RW + DG;
  localparam int K   = CW + RW;
  localparam int MW  = CW + 1;
  localparam int PRW = CW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << K) + 64'(DEN) - 64'd1) / 64'(DEN));

  logic          vld  [1:ND];
  logic [PW-1:0] num  [1:ND];
  logic [RW-1:0] rem  [1:ND];
  logic [SW-1:0] side [1:ND];

  for (genvar k = 0; k < ND; k++) begin : g_digit
    logic           v_in;
    logic [PW-1:0]  n_in;
    logic [RW-1:0]  r_in;
    logic [SW-1:0]  s_in;
    logic [CW-1:0]  cur;
    logic           a_vld;
    logic [CW-1:0]  a_cur;
    logic [PRW-1:0] a_prod;
    logic [PW-1:0]  a_num;
    logic [SW-1:0]  a_side;
    logic [DG-1:0]  qd;
    logic [CW-1:0]  back;
    logic [CW-1:0]  diff;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = PW'(in_num);
      assign r_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k];
      assign n_in = num[k];
      assign r_in = rem[k];
      assign s_in = side[k];
    end

    assign cur  = {r_in, n_in[PW-1 -: DG]};
    assign qd   = a_prod[K +: DG];
    assign back = CW'(qd) * CW'(DEN);
    assign diff = a_cur - back;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld    <= 1'b0;
        vld[k+1] <= 1'b0;
      end else begin
        a_vld    <= v_in;
        vld[k+1] <= a_vld;
      end
    end

    always_ff @(posedge clk) begin
      a_cur     <= cur;
      a_prod    <= PRW'(cur) * PRW'(RECIP);
      a_num     <= {n_in[PW-DG-1:0], {DG{1'b0}}};
      a_side    <= s_in;
      num[k+1]  <= {a_num[PW-1:DG], qd};
      rem[k+1]  <= diff[RW-1:0];
      side[k+1] <= a_side;
    end
  end

  assign out_valid = vld[ND];
  assign out_quo   = num[ND][DW-1:0];
  assign out_side  = side[ND];

endmodule
`default_nettype wire

// ===== rtl/core/etof_sqrt.sv =====
`default_nettype none
module etof_sqrt #(
  parameter int W  = 4,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [W-1:0]    in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W/2-1:0]  out_root,
  output logic [W/2:0]    out_rem,
  output logic [SW-1:0]   out_side
);

  localparam int R = W / 2;

  logic          vld  [1:R];
  logic [W-1:0]  rad  [1:R];
  logic [R-1:0]  root [1:R];
  logic [R:0]    rem  [1:R];
  logic [SW-1:0] side [1:R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic          v_in;
    logic [W-1:0]  a_in;
    logic [R-1:0]  q_in;
    logic [R:0]    r_in;
    logic [SW-1:0] s_in;
    logic [R+2:0]  cat;
    logic [R+2:0]  trial;
    logic [R+2:0]  diff;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign a_in = in_rad;
      assign q_in = '0;
      assign r_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k];
      assign a_in = rad[k];
      assign q_in = root[k];
      assign r_in = rem[k];
      assign s_in = side[k];
    end

    assign cat   = {r_in, a_in[W-1:W-2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign diff  = cat - trial;
    assign take  = cat >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rad[k+1]  <= {a_in[W-3:0], 2'b00};
      root[k+1] <= {q_in[R-2:0], take};
      rem[k+1]  <= take ? diff[R:0] : cat[R:0];
      side[k+1] <= s_in;
    end
  end

  assign out_valid = vld[R];
  assign out_root  = root[R];
  assign out_rem   = rem[R];
  assign out_side  = side[R];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rem <= {out_root, 1'b0})
    else $error("root remainder above twice the root");

endmodule
`default_nettype wire

// ===== rtl/core/energy_to_time_of_flight.sv =====
// Throughput: one word per cycle; busy stays low, start is taken every cycle.
// Three 8-stage constant dividers, the 30-stage root and the 40-stage divider set the depth.
// Reset clears the pipeline valid bits and loads the register defaults.
// Results leave on done for one cycle; the receiver cannot stall.
`default_nettype none
module energy_to_time_of_flight
  import etof_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [X_W-1:0]           deposit_energy,
  output logic                     done,
  output logic signed [FT_W-1:0]   flight_time,
  output logic [ST_W-1:0]          status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam logic signed [T_W-1:0] T_MAX = 42'sd65535;
  localparam logic signed [T_W-1:0] T_MIN = -42'sd5000;

  function automatic logic signed [SUM_W-1:0] xmul(input logic [X_W-1:0] x,
                                                   input logic signed [COEF_W-1:0] v);
    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] vs;
    xs = signed'(SUM_W'(x));
    vs = SUM_W'(v);
    return xs * vs;
  endfunction

  function automatic logic [MAG_W-1:0] rmag(input logic signed [SUM_W-1:0] s,
                                            input logic [SUM_W-1:0] h);
    logic [SUM_W-1:0] u;
    u = s[SUM_W-1] ? (~s + h + SUM_W'(1)) : (s + h);
    return u[MAG_W-1:0];
  endfunction

  logic accept;
  logic [DL_W-1:0]        dead_layer;
  logic signed [TO_W-1:0] time_offset;
  logic [FC_W-1:0]        flight_constant;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_layer      <= DL_RESET;
      time_offset     <= TO_RESET;
      flight_constant <= FC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEAD_LAYER:      dead_layer      <= cfg_data[DL_W-1:0];
        CFG_TIME_OFFSET:     time_offset     <= signed'(cfg_data[TO_W-1:0]);
        CFG_FLIGHT_CONSTANT: flight_constant <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // front: powers of the dead layer and the coefficients
  logic a_vld, b_vld, c_vld, e_vld, f_vld, g_vld;
  logic [X_W-1:0]           a_x, b_x, c_x, e_x;
  logic [DL_W-1:0]          a_d, b_d, c_d;
  logic signed [TO_W-1:0]   a_to, b_to, c_to, e_to;
  logic [FC_W-1:0]          a_k;
  logic [KN_W-1:0]          b_num, c_num, e_num;
  logic [D2_W-1:0]          b_d2, c_d2;
  logic [D3_W-1:0]          c_d3;
  logic signed [COEF_W-1:0] e_n4, e_n3, e_n2, e_n1, e_n0;
  logic signed [SUM_W-1:0]  dl, dl2, dl3;
  logic signed [SUM_W-1:0]  n4c, n3c, n2c, n1c, n0c;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      e_vld <= 1'b0;
    end else begin
      a_vld <= accept;
      b_vld <= a_vld;
      c_vld <= b_vld;
      e_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_x   <= deposit_energy;
    a_d   <= dead_layer;
    a_to  <= time_offset;
    a_k   <= flight_constant;
    b_x   <= a_x;
    b_d   <= a_d;
    b_to  <= a_to;
    b_d2  <= D2_W'(a_d) * D2_W'(a_d);
    b_num <= KN_W'(a_k) * KN_W'(FC_SCALE);
    c_x   <= b_x;
    c_d   <= b_d;
    c_to  <= b_to;
    c_num <= b_num;
    c_d2  <= b_d2;
    c_d3  <= D3_W'(b_d2) * D3_W'(b_d);
  end

  always_comb begin
    dl  = signed'(SUM_W'(c_d));
    dl2 = signed'(SUM_W'(c_d2));
    dl3 = signed'(SUM_W'(c_d3));
    n4c = 64'sd36520000000 - 64'sd865200000 * dl + 64'sd405900 * dl2
          - 64'sd1294 * dl3;
    n3c = -64'sd82580000000 + 64'sd4031000000 * dl + 64'sd96730 * dl2
          + 64'sd3661 * dl3;
    n2c = 64'sd29900000000 - 64'sd7937000000 * dl - 64'sd2219000 * dl2
          - 64'sd2877 * dl3;
    n1c = 64'sd100000000000000 + 64'sd87030000000 * dl + 64'sd12520000 * dl2
          + 64'sd6948 * dl3;
    n0c = -64'sd517400000000 + 64'sd41720000000 * dl + 64'sd36100000 * dl2
          - 64'sd1286 * dl3;
  end

  always_ff @(posedge clk) begin
    e_x   <= c_x;
    e_to  <= c_to;
    e_num <= c_num;
    e_n4  <= COEF_W'(n4c);
    e_n3  <= COEF_W'(n3c);
    e_n2  <= COEF_W'(n2c);
    e_n1  <= COEF_W'(n1c);
    e_n0  <= COEF_W'(n0c);
  end

  // Horner step one
  logic signed [SUM_W-1:0] f_p, f_c, g_sum;
  side_t f_side, g_side, g_side_next;
  logic [MAG_W-1:0] g_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  assign g_sum = f_c + f_p;

  always_comb begin
    g_side_next     = f_side;
    g_side_next.neg = g_sum[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    f_p         <= xmul(e_x, e_n4);
    f_c         <= SUM_W'(e_n3) * 64'sd1000;
    f_side.x    <= e_x;
    f_side.to   <= e_to;
    f_side.num  <= e_num;
    f_side.n2   <= e_n2;
    f_side.n1   <= e_n1;
    f_side.n0   <= e_n0;
    f_side.neg  <= 1'b0;
    f_side.cls  <= ST_OK;
    g_mag       <= rmag(g_sum, SUM_W'(500));
    g_side      <= g_side_next;
  end

  logic             q1_vld;
  logic [MAG_W-1:0] q1_quo;
  side_t            q1_side;

  etof_cdiv #(.DW(MAG_W), .DEN(1000), .SW($bits(side_t))) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_vld),
    .in_num   (g_mag),
    .in_side  (g_side),
    .out_valid(q1_vld),
    .out_quo  (q1_quo),
    .out_side (q1_side)
  );

  // Horner step two
  logic h_vld, i_vld, j_vld;
  logic signed [COEF_W-1:0] q1_v, h_v;
  logic signed [SUM_W-1:0]  i_p, i_c, j_sum;
  side_t h_side, i_side, j_side, j_side_next;
  logic [MAG_W-1:0] j_mag;

  assign q1_v  = signed'(q1_quo[COEF_W-1:0]);
  assign j_sum = i_c + i_p;

  always_comb begin
    j_side_next     = i_side;
    j_side_next.neg = j_sum[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
      i_vld <= 1'b0;
      j_vld <= 1'b0;
    end else begin
      h_vld <= q1_vld;
      i_vld <= h_vld;
      j_vld <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    h_v        <= q1_side.neg ? -q1_v : q1_v;
    h_side     <= q1_side;
    i_p        <= xmul(h_side.x, h_v);
    i_c        <= SUM_W'(h_side.n2) * 64'sd1000;
    i_side     <= h_side;
    j_mag      <= rmag(j_sum, SUM_W'(500));
    j_side     <= j_side_next;
  end

  logic             q2_vld;
  logic [MAG_W-1:0] q2_quo;
  side_t            q2_side;

  etof_cdiv #(.DW(MAG_W), .DEN(1000), .SW($bits(side_t))) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (j_vld),
    .in_num   (j_mag),
    .in_side  (j_side),
    .out_valid(q2_vld),
    .out_quo  (q2_quo),
    .out_side (q2_side)
  );

  // Horner step three
  logic k_vld, l_vld, m_vld;
  logic signed [COEF_W-1:0] q2_v, k_v;
  logic signed [SUM_W-1:0]  l_p, l_c, m_sum;
  side_t k_side, l_side, m_side, m_side_next;
  logic [MAG_W-1:0] m_mag;

  assign q2_v  = signed'(q2_quo[COEF_W-1:0]);
  assign m_sum = l_c + l_p;

  always_comb begin
    m_side_next     = l_side;
    m_side_next.neg = m_sum[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
      l_vld <= 1'b0;
      m_vld <= 1'b0;
    end else begin
      k_vld <= q2_vld;
      l_vld <= k_vld;
      m_vld <= l_vld;
    end
  end

  always_ff @(posedge clk) begin
    k_v        <= q2_side.neg ? -q2_v : q2_v;
    k_side     <= q2_side;
    l_p        <= xmul(k_side.x, k_v);
    l_c        <= SUM_W'(k_side.n1) * 64'sd100;
    l_side     <= k_side;
    m_mag      <= rmag(m_sum, SUM_W'(5000));
    m_side     <= m_side_next;
  end

  logic             q3_vld;
  logic [MAG_W-1:0] q3_quo;
  side_t            q3_side;

  etof_cdiv #(.DW(MAG_W), .DEN(10000), .SW($bits(side_t))) u_div3 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m_vld),
    .in_num   (m_mag),
    .in_side  (m_side),
    .out_valid(q3_vld),
    .out_quo  (q3_quo),
    .out_side (q3_side)
  );

  // kinetic energy and its class
  logic n_vld, o_vld, p_vld;
  logic signed [COEF_W-1:0] q3_v, n_v;
  logic signed [SUM_W-1:0]  o_p, ek;
  side_t n_side, o_side, p_side, p_side_next;
  logic [EK_W-1:0] p_rad, p_rad_next;

  assign q3_v = signed'(q3_quo[COEF_W-1:0]);
  assign ek   = SUM_W'(o_side.n0) + o_p;

  always_comb begin
    p_side_next = o_side;
    p_rad_next  = '0;
    if (ek == '0) begin
      p_side_next.cls = ST_ZERO;
    end else if (ek[SUM_W-1]) begin
      p_side_next.cls = ST_NEG;
    end else begin
      p_side_next.cls = ST_OK;
      p_rad_next      = ek[EK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
      o_vld <= 1'b0;
      p_vld <= 1'b0;
    end else begin
      n_vld <= q3_vld;
      o_vld <= n_vld;
      p_vld <= o_vld;
    end
  end

  always_ff @(posedge clk) begin
    n_v    <= q3_side.neg ? -q3_v : q3_v;
    n_side <= q3_side;
    o_p    <= xmul(n_side.x, n_v);
    o_side <= n_side;
    p_side <= p_side_next;
    p_rad  <= p_rad_next;
  end

  logic              sq_vld;
  logic [EK_W/2-1:0] sq_root;
  logic [EK_W/2:0]   sq_rem;
  side_t             sq_side;

  etof_sqrt #(.W(EK_W), .SW($bits(side_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p_vld),
    .in_rad   (p_rad),
    .in_side  (p_side),
    .out_valid(sq_vld),
    .out_root (sq_root),
    .out_rem  (sq_rem),
    .out_side (sq_side)
  );

  // round the root, then divide the constant by it
  logic             r_vld;
  logic [S_W-1:0]   sq_s;
  logic [NUM_W-1:0] r_num;
  logic [S_W-1:0]   r_den;
  side_t            r_side;

  assign sq_s = (sq_rem > S_W'(sq_root)) ? S_W'(sq_root) + S_W'(1) : S_W'(sq_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    r_num  <= NUM_W'(sq_side.num) + NUM_W'(sq_s >> 1);
    r_den  <= sq_s;
    r_side <= sq_side;
  end

  logic             q4_vld;
  logic [NUM_W-1:0] q4_quo;
  side_t            q4_side;

  etof_div #(.DW(NUM_W), .VW(S_W), .SW($bits(side_t))) u_div4 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_vld),
    .in_num   (r_num),
    .in_den   (r_den),
    .in_side  (r_side),
    .out_valid(q4_vld),
    .out_quo  (q4_quo),
    .out_side (q4_side)
  );

  // add the offset, clamp, drive the word out
  logic signed [T_W-1:0]  t_sum;
  logic signed [FT_W-1:0] ft_next;
  st_t                    st_next;

  assign t_sum = signed'(T_W'(q4_quo)) + T_W'(q4_side.to);

  always_comb begin
    case (q4_side.cls)
      ST_ZERO: begin
        ft_next = '0;
        st_next = ST_ZERO;
      end
      ST_NEG: begin
        ft_next = '0;
        st_next = ST_NEG;
      end
      default: begin
        if (t_sum > T_MAX) begin
          ft_next = FT_W'(T_MAX);
          st_next = ST_SAT;
        end else if (t_sum < T_MIN) begin
          ft_next = FT_W'(T_MIN);
          st_next = ST_SAT;
        end else begin
          ft_next = FT_W'(t_sum);
          st_next = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q4_vld;
    end
  end

  always_ff @(posedge clk) begin
    flight_time <= ft_next;
    status      <= st_next;
  end

  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_ZERO || status == ST_NEG) |-> flight_time == '0)
    else $error("flight time nonzero on a zero or negative energy");

  a_time_floor: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK || status == ST_SAT) |-> flight_time >= FT_W'(T_MIN))
    else $error("flight time below the lower clamp");

  a_root_live: assert property (@(posedge clk) disable iff (rst)
    sq_vld && sq_side.cls == ST_OK |-> sq_root != '0)
    else $error("zero root for a positive energy");

endmodule
`default_nettype wire
